[src/glyph_id_and_metrics_lookup_defines.svh]
// Assertion macros shared by the glyph lookup modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef GLYPH_ID_AND_METRICS_LOOKUP_DEFINES_SVH
`define GLYPH_ID_AND_METRICS_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GML_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph lookup: same-cycle property failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GML_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph lookup: next-cycle property failed");

`else

`define GML_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define GML_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[src/gml_pkg.sv]
`timescale 1ns / 1ps

package gml_pkg;

   // Font layout constants.
   localparam int FIRST_CODE  = 32;
   localparam int DENSE_COUNT = 95;
   localparam int SLOT_STRIDE = 512;
   localparam int SLOT_COUNT  = 16;
   localparam int EXT_DEPTH   = 1024;
   localparam int QMARK_CODE  = 63;

   // Extended hits at or past this position do not fit in the slot.
   localparam int EXT_FIT = SLOT_STRIDE - DENSE_COUNT;

   // Dense index of the replacement glyph, or zero if it lies outside the dense range.
   localparam int FALLBACK_INDEX =
      (QMARK_CODE >= FIRST_CODE && QMARK_CODE - FIRST_CODE < DENSE_COUNT) ?
      QMARK_CODE - FIRST_CODE : 0;

   // Field widths.
   localparam int CMD_W     = 2;
   localparam int IDX_W     = 10;
   localparam int CP_W      = 21;
   localparam int FIELD_W   = 8;
   localparam int REC_W     = 5 * FIELD_W;
   localparam int GID_W     = 13;
   localparam int OY_W      = 10;
   localparam int SLOT_W    = $clog2(SLOT_COUNT);
   localparam int CNT_REG_W = 11;

   // Derived address and index widths.
   localparam int DENSE_AW  = $clog2(DENSE_COUNT);
   localparam int EXT_AW    = $clog2(EXT_DEPTH);
   localparam int EXT_CNT_W = $clog2(EXT_DEPTH + 1);
   localparam int GI_W      = $clog2(SLOT_STRIDE);

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_DENSE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_EXT   = 2'd2;

   // Register map.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CNT_REG_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_ENTRIES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_ASCENT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_TENANT  = 2'd3;

   // What the back end has to do with a queued word.
   typedef enum logic [1:0] {
      KIND_LOOKUP_DENSE,
      KIND_LOOKUP_EXT,
      KIND_LOAD_DENSE,
      KIND_LOAD_EXT
   } kind_type;

   // One queued word. For a dense lookup, index holds the dense position.
   typedef struct packed {
      kind_type            kind;
      logic [IDX_W-1:0]    index;
      logic [CP_W-1:0]     codepoint;
      logic [REC_W-1:0]    record;
   } item_type;

   // Configuration registers.
   typedef struct packed {
      logic [SLOT_W-1:0]    active_slot;
      logic [CNT_REG_W-1:0] ext_entries;
      logic [FIELD_W-1:0]   font_ascent;
      logic                 has_tenant;
   } cfg_type;

endpackage

[src/gml_ram.sv]
`timescale 1ns / 1ps

module gml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/gml_front.sv]
`timescale 1ns / 1ps
`include "glyph_id_and_metrics_lookup_defines.svh"

module gml_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gml_pkg::CMD_W-1:0]     req_command,
   input  logic [gml_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [gml_pkg::CP_W-1:0]      req_codepoint,
   input  logic signed [gml_pkg::FIELD_W-1:0] req_left_bearing,
   input  logic signed [gml_pkg::FIELD_W-1:0] req_top_bearing,
   input  logic [gml_pkg::FIELD_W-1:0]   req_glyph_w,
   input  logic [gml_pkg::FIELD_W-1:0]   req_glyph_h,
   input  logic [gml_pkg::FIELD_W-1:0]   req_glyph_advance,
   input  logic                          pop,
   output logic                          head_valid,
   output gml_pkg::item_type             head
);
   import gml_pkg::*;

   localparam logic [QCNT_W-1:0] FULL_COUNT = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);

   item_type            item;
   logic                keep;
   logic                push;
   logic [CP_W-1:0]     cp_off;
   logic                dense_hit;

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   // Classify the incoming word and drop those that change nothing.
   always_comb begin
      cp_off    = req_codepoint - CP_W'(FIRST_CODE);
      dense_hit = (req_codepoint >= CP_W'(FIRST_CODE)) &&
                  (32'(cp_off) < DENSE_COUNT);
      item.index     = req_entry_index;
      item.codepoint = req_codepoint;
      item.record    = {req_glyph_advance, req_glyph_h, req_glyph_w,
                        req_top_bearing, req_left_bearing};
      item.kind      = KIND_LOOKUP_EXT;
      keep           = 1'b0;
      case (req_command)
         CMD_LOOKUP: begin
            keep = 1'b1;
            if (dense_hit) begin
               item.kind  = KIND_LOOKUP_DENSE;
               item.index = IDX_W'(cp_off);
            end
         end
         CMD_LOAD_DENSE: begin
            item.kind = KIND_LOAD_DENSE;
            keep      = 32'(req_entry_index) < DENSE_COUNT;
         end
         CMD_LOAD_EXT: begin
            item.kind = KIND_LOAD_EXT;
            keep      = 32'(req_entry_index) < EXT_DEPTH;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy = (count_ff == FULL_COUNT);
   assign push = start && !busy && keep;

   // Small queue that lets the front take words while the back is searching.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entries_ff[wr_ptr_ff] <= item;
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   // The back end only takes a word that is there, and a pushed word is seen.
   `GML_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, count_ff != '0)
   `GML_ASSERT_NEXT(a_push_visible, clock, reset, push, head_valid)

endmodule

[src/gml_back.sv]
`timescale 1ns / 1ps
`include "glyph_id_and_metrics_lookup_defines.svh"

module gml_back (
   input  logic                                clock,
   input  logic                                reset,
   input  gml_pkg::cfg_type                    cfg,
   input  logic                                head_valid,
   input  gml_pkg::item_type                   head,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic [gml_pkg::GID_W-1:0]           rsp_glyph_id,
   output logic signed [gml_pkg::FIELD_W-1:0]  rsp_offset_x,
   output logic signed [gml_pkg::OY_W-1:0]     rsp_offset_y,
   output logic [gml_pkg::FIELD_W-1:0]         rsp_box_w,
   output logic [gml_pkg::FIELD_W-1:0]         rsp_box_h,
   output logic [gml_pkg::FIELD_W-1:0]         rsp_advance_width
);
   import gml_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_REC_RD,
      ST_REC_DATA
   } state_type;

   state_type              state_ff;
   logic [EXT_CNT_W-1:0]   lo_ff;
   logic [EXT_CNT_W-1:0]   hi_ff;
   logic [EXT_AW-1:0]      mid_ff;
   logic [CP_W-1:0]        cp_ff;
   logic [GI_W-1:0]        gi_ff;
   logic                   ext_src_ff;
   logic [DENSE_AW-1:0]    dense_addr_ff;
   logic [EXT_AW-1:0]      ext_addr_ff;

   logic                   rsp_valid_ff;
   logic [GID_W-1:0]       glyph_id_ff;
   logic [FIELD_W-1:0]     offset_x_ff;
   logic [OY_W-1:0]        offset_y_ff;
   logic [FIELD_W-1:0]     box_w_ff;
   logic [FIELD_W-1:0]     box_h_ff;
   logic [FIELD_W-1:0]     advance_ff;

   logic [EXT_CNT_W:0]     mid_sum;
   logic [EXT_AW-1:0]      mid;
   logic [EXT_CNT_W-1:0]   hi_init;
   logic                   dense_we;
   logic                   ext_we;
   logic [REC_W-1:0]       dense_rd;
   logic [REC_W-1:0]       ext_rd;
   logic [CP_W-1:0]        key_rd;
   logic [REC_W-1:0]       rec;
   logic [FIELD_W-1:0]     rec_by;
   logic [OY_W-1:0]        offset_y;

   // Loads are written straight from the queue head when it is taken.
   assign pop      = (state_ff == ST_IDLE) && head_valid;
   assign dense_we = pop && (head.kind == KIND_LOAD_DENSE);
   assign ext_we   = pop && (head.kind == KIND_LOAD_EXT);

   // Search midpoint and the saturated search length.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = EXT_AW'(mid_sum >> 1);
   assign hi_init = (32'(cfg.ext_entries) > EXT_DEPTH) ? EXT_CNT_W'(EXT_DEPTH) :
                    EXT_CNT_W'(cfg.ext_entries);

   gml_ram #(.WIDTH(REC_W), .DEPTH(DENSE_COUNT)) u_dense_ram (
      .clock   (clock),
      .wr_en   (dense_we),
      .wr_addr (DENSE_AW'(head.index)),
      .wr_data (head.record),
      .rd_addr (dense_addr_ff),
      .rd_data (dense_rd)
   );

   gml_ram #(.WIDTH(CP_W), .DEPTH(EXT_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (ext_we),
      .wr_addr (EXT_AW'(head.index)),
      .wr_data (head.codepoint),
      .rd_addr (mid),
      .rd_data (key_rd)
   );

   gml_ram #(.WIDTH(REC_W), .DEPTH(EXT_DEPTH)) u_ext_ram (
      .clock   (clock),
      .wr_en   (ext_we),
      .wr_addr (EXT_AW'(head.index)),
      .wr_data (head.record),
      .rd_addr (ext_addr_ff),
      .rd_data (ext_rd)
   );

   // Unpack the resolved record.
   assign rec      = ext_src_ff ? ext_rd : dense_rd;
   assign rec_by   = rec[2*FIELD_W-1:FIELD_W];
   assign offset_y = {{(OY_W-FIELD_W){1'b0}}, cfg.font_ascent} -
                     {{(OY_W-FIELD_W){rec_by[FIELD_W-1]}}, rec_by};

   // Sequencer: binary search, record fetch and result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  case (head.kind)
                     KIND_LOOKUP_DENSE: begin
                        gi_ff         <= GI_W'(head.index);
                        ext_src_ff    <= 1'b0;
                        dense_addr_ff <= DENSE_AW'(head.index);
                        state_ff      <= ST_REC_RD;
                     end
                     KIND_LOOKUP_EXT: begin
                        cp_ff    <= head.codepoint;
                        lo_ff    <= '0;
                        hi_ff    <= hi_init;
                        state_ff <= ST_PROBE;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid;
                  state_ff <= ST_CMP;
               end else begin
                  // Miss: fall back to the replacement glyph.
                  gi_ff         <= GI_W'(FALLBACK_INDEX);
                  ext_src_ff    <= 1'b0;
                  dense_addr_ff <= DENSE_AW'(FALLBACK_INDEX);
                  state_ff      <= ST_REC_RD;
               end
            end
            ST_CMP: begin
               if (key_rd == cp_ff) begin
                  if (32'(mid_ff) < EXT_FIT) begin
                     gi_ff       <= GI_W'(DENSE_COUNT + 32'(mid_ff));
                     ext_src_ff  <= 1'b1;
                     ext_addr_ff <= mid_ff;
                  end else begin
                     gi_ff         <= GI_W'(FALLBACK_INDEX);
                     ext_src_ff    <= 1'b0;
                     dense_addr_ff <= DENSE_AW'(FALLBACK_INDEX);
                  end
                  state_ff <= ST_REC_RD;
               end else if (key_rd < cp_ff) begin
                  lo_ff    <= EXT_CNT_W'(mid_ff) + EXT_CNT_W'(1);
                  state_ff <= ST_PROBE;
               end else begin
                  hi_ff    <= EXT_CNT_W'(mid_ff);
                  state_ff <= ST_PROBE;
               end
            end
            ST_REC_RD: begin
               state_ff <= ST_REC_DATA;
            end
            ST_REC_DATA: begin
               glyph_id_ff  <= GID_W'(32'(cfg.active_slot) * SLOT_STRIDE) + GID_W'(gi_ff);
               offset_x_ff  <= rec[FIELD_W-1:0];
               offset_y_ff  <= offset_y;
               box_w_ff     <= cfg.has_tenant ? rec[3*FIELD_W-1:2*FIELD_W] : '0;
               box_h_ff     <= cfg.has_tenant ? rec[4*FIELD_W-1:3*FIELD_W] : '0;
               advance_ff   <= rec[5*FIELD_W-1:4*FIELD_W];
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_glyph_id      = glyph_id_ff;
   assign rsp_offset_x      = offset_x_ff;
   assign rsp_offset_y      = offset_y_ff;
   assign rsp_box_w         = box_w_ff;
   assign rsp_box_h         = box_h_ff;
   assign rsp_advance_width = advance_ff;

   // A probe always lies inside a non-empty window, and each lookup gives one word.
   `GML_ASSERT_IMPLY(a_probe_window, clock, reset, state_ff == ST_CMP, lo_ff < hi_ff)
   `GML_ASSERT_NEXT(a_word_follows, clock, reset, state_ff == ST_REC_DATA, rsp_valid_ff)
   `GML_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)

endmodule

[src/glyph_id_and_metrics_lookup.sv]
`timescale 1ns / 1ps

// Glyph ID and metrics lookup for one font. A word is taken when start is high
// and busy is low; command 0 looks up a codepoint, 1 and 2 load a dense or an
// extended record, and other commands or out-of-range loads are dropped. Each
// lookup gives exactly one result word, shown for one cycle with rsp_valid
// high; the receiver cannot stall it, so it must take every strobe. Loads and
// dropped words give no result. A two-word queue sits between the classifying
// front and the search back end, so busy rises only when that queue is full.
// A load is written as the back end takes it, leaving the back end idle. A
// dense lookup goes from the queue through the idle, record read and record
// data states, where the result word is registered. An extended lookup first
// runs a binary search over the key memory, a probe and a compare state per
// probe for its registered read, up to ceil(log2(N + 1)) probes for N entries.
// Records and keys have no reset; read an entry only after it was loaded.
// The user writes registers through the csr port only while no lookup is pending; the block does not enforce it.

module glyph_id_and_metrics_lookup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [gml_pkg::CMD_W-1:0]           req_command,
   input  logic [gml_pkg::IDX_W-1:0]           req_entry_index,
   input  logic [gml_pkg::CP_W-1:0]            req_codepoint,
   input  logic signed [gml_pkg::FIELD_W-1:0]  req_left_bearing,
   input  logic signed [gml_pkg::FIELD_W-1:0]  req_top_bearing,
   input  logic [gml_pkg::FIELD_W-1:0]         req_glyph_w,
   input  logic [gml_pkg::FIELD_W-1:0]         req_glyph_h,
   input  logic [gml_pkg::FIELD_W-1:0]         req_glyph_advance,
   output logic                                rsp_valid,
   output logic [gml_pkg::GID_W-1:0]           rsp_glyph_id,
   output logic signed [gml_pkg::FIELD_W-1:0]  rsp_offset_x,
   output logic signed [gml_pkg::OY_W-1:0]     rsp_offset_y,
   output logic [gml_pkg::FIELD_W-1:0]         rsp_box_w,
   output logic [gml_pkg::FIELD_W-1:0]         rsp_box_h,
   output logic [gml_pkg::FIELD_W-1:0]         rsp_advance_width,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gml_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gml_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gml_pkg::*;

   cfg_type  cfg_ff;
   logic     head_valid;
   item_type head;
   logic     pop;

   // Register file: always ready, one register per write word.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_SLOT: cfg_ff.active_slot <= csr_wdata[SLOT_W-1:0];
            CSR_EXT_ENTRIES: cfg_ff.ext_entries <= csr_wdata[CNT_REG_W-1:0];
            CSR_FONT_ASCENT: cfg_ff.font_ascent <= csr_wdata[FIELD_W-1:0];
            CSR_HAS_TENANT:  cfg_ff.has_tenant  <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   gml_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_codepoint     (req_codepoint),
      .req_left_bearing  (req_left_bearing),
      .req_top_bearing   (req_top_bearing),
      .req_glyph_w       (req_glyph_w),
      .req_glyph_h       (req_glyph_h),
      .req_glyph_advance (req_glyph_advance),
      .pop               (pop),
      .head_valid        (head_valid),
      .head              (head)
   );

   gml_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_glyph_id      (rsp_glyph_id),
      .rsp_offset_x      (rsp_offset_x),
      .rsp_offset_y      (rsp_offset_y),
      .rsp_box_w         (rsp_box_w),
      .rsp_box_h         (rsp_box_h),
      .rsp_advance_width (rsp_advance_width)
   );

endmodule

[sim/glyph_lookup_checker.sv]
`timescale 1ns / 1ps

module glyph_lookup_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [gml_pkg::CMD_W-1:0]           req_command,
   input  logic [gml_pkg::IDX_W-1:0]           req_entry_index,
   input  logic [gml_pkg::CP_W-1:0]            req_codepoint,
   input  logic signed [gml_pkg::FIELD_W-1:0]  req_left_bearing,
   input  logic signed [gml_pkg::FIELD_W-1:0]  req_top_bearing,
   input  logic [gml_pkg::FIELD_W-1:0]         req_glyph_w,
   input  logic [gml_pkg::FIELD_W-1:0]         req_glyph_h,
   input  logic [gml_pkg::FIELD_W-1:0]         req_glyph_advance,
   input  logic                                rsp_valid,
   input  logic [gml_pkg::GID_W-1:0]           rsp_glyph_id,
   input  logic signed [gml_pkg::FIELD_W-1:0]  rsp_offset_x,
   input  logic signed [gml_pkg::OY_W-1:0]     rsp_offset_y,
   input  logic [gml_pkg::FIELD_W-1:0]         rsp_box_w,
   input  logic [gml_pkg::FIELD_W-1:0]         rsp_box_h,
   input  logic [gml_pkg::FIELD_W-1:0]         rsp_advance_width,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [gml_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gml_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   import gml_pkg::*;

   // One glyph record as the load commands deliver it.
   typedef struct packed {
      logic signed [FIELD_W-1:0] left_bearing;
      logic signed [FIELD_W-1:0] top_bearing;
      logic [FIELD_W-1:0]        width;
      logic [FIELD_W-1:0]        height;
      logic [FIELD_W-1:0]        advance;
   } glyph_record_type;

   // One result word: where and how large the resolved glyph is drawn.
   typedef struct packed {
      logic [GID_W-1:0]          glyph_id;
      logic signed [FIELD_W-1:0] offset_x;
      logic signed [OY_W-1:0]    offset_y;
      logic [FIELD_W-1:0]        box_w;
      logic [FIELD_W-1:0]        box_h;
      logic [FIELD_W-1:0]        advance_width;
   } glyph_placement_type;

   // Shadow copy of the font stores and registers.
   glyph_record_type     dense_glyphs [DENSE_COUNT];
   logic [CP_W-1:0]      key_table [EXT_DEPTH];
   glyph_record_type     ext_glyphs [EXT_DEPTH];
   logic [SLOT_W-1:0]    slot_sel;
   logic [CNT_REG_W-1:0] search_count;
   logic [FIELD_W-1:0]   ascent_px;
   logic                 tenant_on;

   glyph_placement_type  expected_placements [$];
   int                   mismatches;

   // Slot-local glyph index that a codepoint resolves to.
   function automatic int unsigned local_glyph_index(input logic [CP_W-1:0] cp);
      int unsigned code;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      code = cp;
      lo = 0;
      hi = (search_count > EXT_DEPTH) ? EXT_DEPTH : search_count;
      // Printable ASCII sits in the dense store at a fixed offset.
      if (code >= FIRST_CODE && code - FIRST_CODE < DENSE_COUNT)
         return code - FIRST_CODE;
      // Binary search over the extended keys; a hit past the slot's room falls back.
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (key_table[mid] == cp)
            return (mid < EXT_FIT) ? DENSE_COUNT + mid : FALLBACK_INDEX;
         if (key_table[mid] < cp) lo = mid + 1;
         else hi = mid;
      end
      return FALLBACK_INDEX;
   endfunction

   // Result word that a lookup of this codepoint must give.
   function automatic glyph_placement_type predict_placement(input logic [CP_W-1:0] cp);
      int unsigned         index;
      int                  vertical;
      glyph_record_type    rec;
      glyph_placement_type place;
      index = local_glyph_index(cp);
      if (index < DENSE_COUNT) rec = dense_glyphs[index];
      else rec = ext_glyphs[index - DENSE_COUNT];
      vertical = int'(ascent_px) - int'($signed(rec.top_bearing));
      place.glyph_id      = GID_W'(slot_sel * SLOT_STRIDE + index);
      place.offset_x      = rec.left_bearing;
      place.offset_y      = OY_W'(vertical);
      place.box_w         = tenant_on ? rec.width : '0;
      place.box_h         = tenant_on ? rec.height : '0;
      place.advance_width = rec.advance;
      return place;
   endfunction

   always @(posedge clock) begin : monitor
      glyph_placement_type got;
      glyph_placement_type want;
      glyph_record_type    loaded;
      if (reset) begin
         slot_sel     = '0;
         search_count = '0;
         ascent_px    = '0;
         tenant_on    = 1'b0;
         mismatches   = 0;
         expected_placements.delete();
      end else begin
         // A result word is compared with the oldest outstanding lookup.
         if (rsp_valid) begin
            got = '{rsp_glyph_id, rsp_offset_x, rsp_offset_y,
                    rsp_box_w, rsp_box_h, rsp_advance_width};
            if (expected_placements.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with no lookup outstanding: id %0d", $realtime,
                           got.glyph_id);
            end else begin
               want = expected_placements.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: lookup mismatch: expected id %0d ox %0d oy %0d w %0d",
                               " h %0d adv %0d, got id %0d ox %0d oy %0d w %0d h %0d adv %0d"},
                              $realtime, want.glyph_id, want.offset_x, want.offset_y,
                              want.box_w, want.box_h, want.advance_width, got.glyph_id,
                              got.offset_x, got.offset_y, got.box_w, got.box_h,
                              got.advance_width);
               end
            end
         end

         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACTIVE_SLOT: slot_sel     = csr_wdata[SLOT_W-1:0];
               CSR_EXT_ENTRIES: search_count = csr_wdata[CNT_REG_W-1:0];
               CSR_FONT_ASCENT: ascent_px    = csr_wdata[FIELD_W-1:0];
               CSR_HAS_TENANT:  tenant_on    = csr_wdata[0];
               default: ;
            endcase
         end

         // Accepted command words update the stores or queue an expected result.
         if (start && !busy) begin
            loaded = '{req_left_bearing, req_top_bearing, req_glyph_w, req_glyph_h,
                       req_glyph_advance};
            case (req_command)
               CMD_LOOKUP: expected_placements.push_back(predict_placement(req_codepoint));
               CMD_LOAD_DENSE: begin
                  if (req_entry_index < DENSE_COUNT) dense_glyphs[req_entry_index] = loaded;
               end
               CMD_LOAD_EXT: begin
                  if (req_entry_index < EXT_DEPTH) begin
                     key_table[req_entry_index]  = req_codepoint;
                     ext_glyphs[req_entry_index] = loaded;
                  end
               end
               default: ;
            endcase
         end
      end
      pending_count  <= expected_placements.size();
      mismatch_count <= mismatches;
   end

endmodule

[sim/tb_glyph_id_and_metrics_lookup.sv]
`timescale 1ns / 1ps

module tb_glyph_id_and_metrics_lookup;

   import gml_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam int MAX_CODEPOINT    = 1114111;
   localparam int MAX_ENTRY_INDEX  = (1 << IDX_W) - 1;
   localparam int RANDOM_PER_PHASE = 86;
   localparam int SETTLE_CYCLES    = 64;
   localparam int STALL_LIMIT      = 2000;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [CMD_W-1:0]            req_command;
   logic [IDX_W-1:0]            req_entry_index;
   logic [CP_W-1:0]             req_codepoint;
   logic signed [FIELD_W-1:0]   req_left_bearing;
   logic signed [FIELD_W-1:0]   req_top_bearing;
   logic [FIELD_W-1:0]          req_glyph_w;
   logic [FIELD_W-1:0]          req_glyph_h;
   logic [FIELD_W-1:0]          req_glyph_advance;
   logic                        rsp_valid;
   logic [GID_W-1:0]            rsp_glyph_id;
   logic signed [FIELD_W-1:0]   rsp_offset_x;
   logic signed [OY_W-1:0]      rsp_offset_y;
   logic [FIELD_W-1:0]          rsp_box_w;
   logic [FIELD_W-1:0]          rsp_box_h;
   logic [FIELD_W-1:0]          rsp_advance_width;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;
   int                          mismatch_count;
   int                          pending_count;

   // Keys as last loaded, used to aim lookups at hits and near misses.
   int key_shadow [EXT_DEPTH];
   int search_span;
   int gap_percent;
   int stall_cycles;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   glyph_id_and_metrics_lookup u_dut (.*);

   glyph_lookup_checker u_checker (.*);

   // End the run when nothing has moved on any channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Record byte that favors the signed and unsigned extremes.
   function automatic logic [FIELD_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   // Lookup codepoint: dense codes, table hits, near misses and anything at all.
   function automatic int pick_codepoint();
      int sel;
      int pos;
      sel = $urandom_range(0, 99);
      if (sel < 30) return $urandom_range(FIRST_CODE, FIRST_CODE + DENSE_COUNT - 1);
      if (sel < 75 && search_span > 0) begin
         pos = $urandom_range(0, search_span - 1);
         if (sel < 60) return key_shadow[pos];
         return key_shadow[pos] ^ 1;
      end
      if (sel < 85) return $urandom_range(0, 255);
      return $urandom_range(0, MAX_CODEPOINT);
   endfunction

   // Present one command word at a falling edge and hold it until it is taken.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input int idx, input int cp);
      int gap;
      if ($urandom_range(0, 99) < gap_percent) begin
         start = 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      start             = 1'b1;
      req_command       = cmd;
      req_entry_index   = IDX_W'(idx);
      req_codepoint     = CP_W'(cp);
      req_left_bearing  = pick_byte();
      req_top_bearing   = pick_byte();
      req_glyph_w       = pick_byte();
      req_glyph_h       = pick_byte();
      req_glyph_advance = pick_byte();
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Wait until every lookup has answered and trailing loads have drained.
   task automatic settle();
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int slot, input int count, input int ascent,
                            input int tenant);
      settle();
      write_register(CSR_ACTIVE_SLOT, slot);
      write_register(CSR_EXT_ENTRIES, count);
      write_register(CSR_FONT_ASCENT, ascent);
      write_register(CSR_HAS_TENANT, tenant);
      search_span = (count > EXT_DEPTH) ? EXT_DEPTH : count;
   endtask

   // Load a strictly increasing key table spread over the codepoint range.
   task automatic fill_extended(input int entries);
      int stride;
      int key;
      stride = MAX_CODEPOINT / entries;
      for (int i = 0; i < entries; i++) begin
         key = i * stride + $urandom_range(0, stride - 1);
         if (i == 0 && $urandom_range(0, 1)) key = $urandom_range(0, FIRST_CODE - 1);
         if (i == entries - 1 && $urandom_range(0, 1)) key = MAX_CODEPOINT;
         key_shadow[i] = key;
         send_word(CMD_LOAD_EXT, i, key);
      end
   endtask

   task automatic random_item();
      int sel;
      int pos;
      int key;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         send_word(CMD_LOOKUP, $urandom_range(0, MAX_ENTRY_INDEX), pick_codepoint());
      end else if (sel < 70) begin
         send_word(CMD_LOAD_DENSE, $urandom_range(0, DENSE_COUNT - 1),
                   $urandom_range(0, MAX_CODEPOINT));
      end else if (sel < 74) begin
         send_word(CMD_LOAD_DENSE, $urandom_range(DENSE_COUNT, MAX_ENTRY_INDEX),
                   $urandom_range(0, MAX_CODEPOINT));
      end else if (sel < 78) begin
         send_word(CMD_RESERVED, $urandom_range(0, MAX_ENTRY_INDEX),
                   $urandom_range(0, MAX_CODEPOINT));
      end else if (sel < 92 && search_span > 0) begin
         // New metrics under an existing key keep the table sorted.
         pos = $urandom_range(0, search_span - 1);
         send_word(CMD_LOAD_EXT, pos, key_shadow[pos]);
      end else if (sel < 98 && search_span < EXT_DEPTH) begin
         // Entries past the searched range are loaded but never searched.
         pos = $urandom_range(search_span, EXT_DEPTH - 1);
         key = $urandom_range(0, MAX_CODEPOINT);
         key_shadow[pos] = key;
         send_word(CMD_LOAD_EXT, pos, key);
      end else begin
         // Any key anywhere, which may leave the searched range unsorted.
         pos = $urandom_range(0, EXT_DEPTH - 1);
         key = $urandom_range(0, MAX_CODEPOINT);
         key_shadow[pos] = key;
         send_word(CMD_LOAD_EXT, pos, key);
      end
   endtask

   task automatic run_random(input int items);
      repeat (items) random_item();
   endtask

   initial begin
      int entries;
      reset             = 1'b1;
      start             = 1'b0;
      req_command       = CMD_LOOKUP;
      req_entry_index   = '0;
      req_codepoint     = '0;
      req_left_bearing  = '0;
      req_top_bearing   = '0;
      req_glyph_w       = '0;
      req_glyph_h       = '0;
      req_glyph_advance = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_ACTIVE_SLOT;
      csr_wdata         = '0;
      gap_percent       = 20;
      search_span       = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty extended table and all registers at their low end.
      configure(0, 0, 0, 0);
      for (int i = 0; i < DENSE_COUNT; i++)
         send_word(CMD_LOAD_DENSE, i, $urandom_range(0, MAX_CODEPOINT));

      // Dense edges, codes just outside them, extreme codepoints and the replacement glyph.
      send_word(CMD_LOOKUP, 0, FIRST_CODE);
      send_word(CMD_LOOKUP, MAX_ENTRY_INDEX, FIRST_CODE + DENSE_COUNT - 1);
      send_word(CMD_LOOKUP, 0, FIRST_CODE - 1);
      send_word(CMD_LOOKUP, 0, FIRST_CODE + DENSE_COUNT);
      send_word(CMD_LOOKUP, 0, 0);
      send_word(CMD_LOOKUP, 0, MAX_CODEPOINT);
      send_word(CMD_LOOKUP, 0, QMARK_CODE);

      // The reserved command and out-of-range dense loads must not touch the stores.
      send_word(CMD_RESERVED, 0, FIRST_CODE);
      send_word(CMD_LOAD_DENSE, DENSE_COUNT, 0);
      send_word(CMD_LOAD_DENSE, MAX_ENTRY_INDEX, MAX_CODEPOINT);
      send_word(CMD_LOOKUP, 0, FIRST_CODE);
      send_word(CMD_LOOKUP, 0, FIRST_CODE + DENSE_COUNT - 1);

      // Rewrite the first dense record and the replacement glyph, then read both back.
      send_word(CMD_LOAD_DENSE, 0, 0);
      send_word(CMD_LOAD_DENSE, QMARK_CODE - FIRST_CODE, 0);
      send_word(CMD_LOOKUP, 0, FIRST_CODE);
      send_word(CMD_LOOKUP, 0, 1000);

      // Extended load at the last position, outside the searched range.
      key_shadow[EXT_DEPTH - 1] = MAX_CODEPOINT;
      send_word(CMD_LOAD_EXT, EXT_DEPTH - 1, MAX_CODEPOINT);
      send_word(CMD_LOOKUP, 0, MAX_CODEPOINT);

      // Small table with the slot, ascent and tenant registers at their high end.
      gap_percent = 30;
      fill_extended(48);
      configure(SLOT_COUNT - 1, 48, 255, 1);
      run_random(RANDOM_PER_PHASE);

      // Full table, so that many hits land past the room left in a slot.
      gap_percent = 0;
      fill_extended(EXT_DEPTH);
      configure($urandom_range(0, SLOT_COUNT - 1), EXT_DEPTH, $urandom_range(0, 255), 1);
      run_random(RANDOM_PER_PHASE);

      // Count register far beyond the table depth; the search length saturates.
      gap_percent = 50;
      configure($urandom_range(0, SLOT_COUNT - 1), (1 << CNT_REG_W) - 1,
                $urandom_range(0, 255), $urandom_range(0, 1));
      run_random(RANDOM_PER_PHASE);

      // Part of the full table, no atlas tenant.
      gap_percent = 15;
      configure($urandom_range(0, SLOT_COUNT - 1), $urandom_range(EXT_FIT + 1, EXT_DEPTH - 1),
                $urandom_range(0, 255), 0);
      run_random(RANDOM_PER_PHASE);

      // Freshly built small tables under random settings.
      repeat (2) begin
         gap_percent = $urandom_range(10, 60);
         entries = $urandom_range(1, 40);
         fill_extended(entries);
         configure($urandom_range(0, SLOT_COUNT - 1), entries, $urandom_range(0, 255),
                   $urandom_range(0, 1));
         run_random(RANDOM_PER_PHASE);
      end

      // Last stretch with the sender never pausing.
      gap_percent = 0;
      entries = $urandom_range(1, 40);
      fill_extended(entries);
      configure($urandom_range(0, SLOT_COUNT - 1), entries, 0, 1);
      run_random(RANDOM_PER_PHASE);

      settle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
